FILE: src/assert_macros.svh
// Assertion macros used by the RTL top level.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: src/ssmh_pkg.sv
// Package for the skyline sweep block: payload types and sizing constants.
// Depends on nothing; used by the RAM-facing top level.
package ssmh_pkg;
   localparam int MaxBuildings = 255;
   localparam int CoordBits = 16;
   localparam int SlotBits = 8;
   localparam int CountBits = 9;
   localparam int HeightBits = 16;
   localparam int LabelBits = 8;
   localparam int EntryBits = HeightBits + LabelBits;
   localparam int Depth = 256;

   localparam logic ReqInsert = 1'b0;
   localparam logic ReqRemove = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [CoordBits-1:0]  x_coord;
      logic [LabelBits-1:0]  building_label;
      logic [HeightBits-1:0] building_height;
      logic                  group_end;
   } req_type_type;

   typedef struct packed {
      logic [CoordBits-1:0]  change_x;
      logic [HeightBits-1:0] new_height;
   } rsp_type;
endpackage

FILE: src/skyline_sweep_max_heap.sv
// Skyline sweep over an indexed max-heap held in two RAMs (heap entries, label map).
// Words are taken one at a time. An insert sifts its entry up; a removal moves the last
// entry into the freed slot and sifts it up, or down if it did not rise. Only a group
// end that changes the height gives a result; it is registered and holds off the next
// word until taken. Reset is synchronous, active high, empties the heap and zeroes the
// reported height; the RAMs are never cleared.
module skyline_sweep_max_heap
   import ssmh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);
`include "assert_macros.svh"

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_LIVE_A = 5'd1;  // read map
   localparam logic [4:0] S_LIVE_B = 5'd2;  // read heap at map slot
   localparam logic [4:0] S_LIVE_C = 5'd3;  // decide
   localparam logic [4:0] S_LAST_R = 5'd4;  // read last entry
   localparam logic [4:0] S_LAST_W = 5'd5;
   localparam logic [4:0] S_UP_R   = 5'd6;  // read parent
   localparam logic [4:0] S_UP_W   = 5'd7;
   localparam logic [4:0] S_UP_C   = 5'd8;  // compare parent
   localparam logic [4:0] S_PUT    = 5'd9;  // write entry at hole
   localparam logic [4:0] S_PUTMAP = 5'd10;
   localparam logic [4:0] S_DN_L   = 5'd11; // read left child
   localparam logic [4:0] S_DN_LW  = 5'd12;
   localparam logic [4:0] S_DN_R   = 5'd13; // read right child
   localparam logic [4:0] S_DN_RW  = 5'd14;
   localparam logic [4:0] S_DN_C   = 5'd15;
   localparam logic [4:0] S_MV     = 5'd16; // hole moves to the child slot
   localparam logic [4:0] S_MVMAP  = 5'd17;
   localparam logic [4:0] S_TOP_R  = 5'd18;
   localparam logic [4:0] S_TOP_W  = 5'd19;
   localparam logic [4:0] S_REPORT = 5'd20;

   logic [4:0]            state_ff, state_in;
   logic [CountBits-1:0]  count_ff, count_in;
   logic [HeightBits-1:0] reported_ff, reported_in;
   req_type_type          req_ff, req_in;
   logic [CountBits-1:0]  hole_ff, hole_in;     // current hole slot
   logic [CountBits-1:0]  start_ff, start_in;   // slot where a removal began
   logic [HeightBits-1:0] eh_ff, eh_in;         // entry being placed
   logic [LabelBits-1:0]  el_ff, el_in;
   logic [EntryBits-1:0]  cand_ff, cand_in;     // parent, chosen child or top entry
   logic [CountBits-1:0]  cslot_ff, cslot_in;
   logic                  down_ff, down_in;     // placing may end in a sift-down
   logic                  moved_ff, moved_in;   // sift-up moved the entry
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  hwe, mwe;
   logic [SlotBits-1:0]   hwa, hra, mwa, mra;
   logic [EntryBits-1:0]  hwd, hrd;
   logic [SlotBits-1:0]   mwd, mrd;

   ssmh_ram #(.Width(EntryBits), .Depth(Depth)) u_heap (
      .clock(clock), .wr_en(hwe), .wr_addr(hwa), .wr_data(hwd),
      .rd_addr(hra), .rd_data(hrd));
   ssmh_ram #(.Width(SlotBits), .Depth(Depth)) u_map (
      .clock(clock), .wr_en(mwe), .wr_addr(mwa), .wr_data(mwd),
      .rd_addr(mra), .rd_data(mrd));

   logic [HeightBits-1:0] rd_h;
   logic [LabelBits-1:0]  rd_l;
   logic [CountBits-1:0]  map_slot;
   logic [HeightBits-1:0] top_h;
   assign rd_h = hrd[EntryBits-1:LabelBits];
   assign rd_l = hrd[LabelBits-1:0];
   assign map_slot = {1'b0, mrd};
   // The skyline height is zero while the heap is empty.
   assign top_h = (count_ff == '0) ? '0 : cand_ff[EntryBits-1:LabelBits];

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      reported_in = reported_ff;
      req_in = req_ff;
      hole_in = hole_ff;
      start_in = start_ff;
      eh_in = eh_ff;
      el_in = el_ff;
      cand_in = cand_ff;
      cslot_in = cslot_ff;
      down_in = down_ff;
      moved_in = moved_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      hwe = 1'b0;
      mwe = 1'b0;
      hwa = hole_ff[SlotBits-1:0];
      hwd = {eh_ff, el_ff};
      mwa = el_ff;
      mwd = hole_ff[SlotBits-1:0];
      hra = hole_ff[SlotBits-1:0];
      mra = req_ff.building_label;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               state_in = S_LIVE_A;
            end
         end
         S_LIVE_A: begin
            mra = req_ff.building_label;
            state_in = S_LIVE_B;
         end
         S_LIVE_B: begin
            hra = mrd;
            start_in = map_slot;
            state_in = S_LIVE_C;
         end
         S_LIVE_C: begin
            // A label is live only when its mapped slot is in use and holds it.
            if (start_ff >= CountBits'(1) && start_ff <= count_ff &&
                  rd_l == req_ff.building_label) begin
               if (req_ff.req_type == ReqInsert) begin
                  state_in = S_TOP_R;
               end else begin
                  state_in = S_LAST_R;
               end
            end else if (req_ff.req_type == ReqInsert &&
                  count_ff < CountBits'(MaxBuildings)) begin
               count_in = count_ff + CountBits'(1);
               hole_in = count_ff + CountBits'(1);
               eh_in = req_ff.building_height;
               el_in = req_ff.building_label;
               down_in = 1'b0;
               moved_in = 1'b0;
               state_in = S_UP_R;
            end else begin
               state_in = S_TOP_R;
            end
         end
         S_LAST_R: begin
            hra = count_ff[SlotBits-1:0];
            state_in = S_LAST_W;
         end
         S_LAST_W: begin
            eh_in = rd_h;
            el_in = rd_l;
            count_in = count_ff - CountBits'(1);
            hole_in = start_ff;
            down_in = 1'b1;
            moved_in = 1'b0;
            if (start_ff <= count_ff - CountBits'(1)) begin
               state_in = S_UP_R;
            end else begin
               state_in = S_TOP_R;
            end
         end
         S_UP_R: begin
            hra = hole_ff[CountBits-1:1];
            cslot_in = {1'b0, hole_ff[CountBits-1:1]};
            if (hole_ff > CountBits'(1)) begin
               state_in = S_UP_W;
            end else begin
               state_in = S_PUT;
            end
         end
         S_UP_W: begin
            cand_in = hrd;
            state_in = S_UP_C;
         end
         S_UP_C: begin
            if (eh_ff > cand_ff[EntryBits-1:LabelBits]) begin
               // Parent moves down into the hole.
               hwe = 1'b1;
               hwd = cand_ff;
               mwe = 1'b1;
               mwa = cand_ff[LabelBits-1:0];
               moved_in = 1'b1;
               hole_in = cslot_ff;
               state_in = S_UP_R;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            hwe = 1'b1;
            state_in = S_PUTMAP;
         end
         S_PUTMAP: begin
            mwe = 1'b1;
            if (down_ff && !moved_ff) begin
               state_in = S_DN_L;
            end else begin
               state_in = S_TOP_R;
            end
         end
         S_DN_L: begin
            hra = SlotBits'({hole_ff, 1'b0});
            cslot_in = {hole_ff[CountBits-2:0], 1'b0};
            if ({hole_ff, 1'b0} <= {1'b0, count_ff}) begin
               state_in = S_DN_LW;
            end else begin
               state_in = S_TOP_R;
            end
         end
         S_DN_LW: begin
            cand_in = hrd;
            if (cslot_ff != count_ff) begin
               state_in = S_DN_R;
            end else begin
               state_in = S_DN_C;
            end
         end
         S_DN_R: begin
            hra = SlotBits'(cslot_ff + CountBits'(1));
            state_in = S_DN_RW;
         end
         S_DN_RW: begin
            if (rd_h > cand_ff[EntryBits-1:LabelBits]) begin
               cand_in = hrd;
               cslot_in = cslot_ff + CountBits'(1);
            end
            state_in = S_DN_C;
         end
         S_DN_C: begin
            if (cand_ff[EntryBits-1:LabelBits] > eh_ff) begin
               // Child moves up into the hole; the entry goes to the child slot.
               hwe = 1'b1;
               hwd = cand_ff;
               mwe = 1'b1;
               mwa = cand_ff[LabelBits-1:0];
               state_in = S_MV;
            end else begin
               state_in = S_TOP_R;
            end
         end
         S_MV: begin
            hole_in = cslot_ff;
            state_in = S_MVMAP;
         end
         S_MVMAP: begin
            hwe = 1'b1;
            mwe = 1'b1;
            state_in = S_DN_L;
         end
         S_TOP_R: begin
            hra = SlotBits'(1);
            state_in = S_TOP_W;
         end
         S_TOP_W: begin
            state_in = S_REPORT;
            cand_in = hrd;
         end
         S_REPORT: begin
            state_in = S_IDLE;
            if (req_ff.group_end && top_h != reported_ff) begin
               reported_in = top_h;
               rsp_in.change_x = req_ff.x_coord;
               rsp_in.new_height = top_h;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         reported_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         reported_ff <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      hole_ff <= hole_in;
      start_ff <= start_in;
      eh_ff <= eh_in;
      el_ff <= el_in;
      cand_ff <= cand_in;
      cslot_ff <= cslot_in;
      down_ff <= down_in;
      moved_ff <= moved_in;
      rsp_ff <= rsp_in;
   end

   `ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CountBits'(MaxBuildings))
   `ASSERT_NEXT(a_rsp_changes, clock, reset, rsp_valid_in && !rsp_valid_ff,
      rsp_data.new_height == reported_ff)
   `ASSERT_IMPL(a_busy, clock, reset, state_ff != S_IDLE, !req_ready)
endmodule

FILE: src/ssmh_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module ssmh_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: test/tb_skyline_sweep_max_heap.sv
// Testbench for skyline_sweep_max_heap: directed table, fill and drain past capacity, then random edge events,
// checked against an in-bench indexed max-heap predictor. Depends on ssmh_pkg.
`timescale 1ns / 1ps
module tb_skyline_sweep_max_heap;
   import ssmh_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   skyline_sweep_max_heap u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Predictor state.
   logic [HeightBits-1:0] sky_h [0:Depth-1];
   logic [LabelBits-1:0]  sky_l [0:Depth-1];
   int unsigned           slot_map [0:255];
   int unsigned           live_count;
   logic [HeightBits-1:0] last_height;
   rsp_type               skyline_q [$];
   int                    push_cnt = 0;
   int                    errors = 0;
   bit                    stim_done = 0;
   bit                    hold_off = 0;

   function automatic void put_entry(int unsigned s, logic [HeightBits-1:0] h,
                                     logic [LabelBits-1:0] l);
      sky_h[s] = h;
      sky_l[s] = l;
      slot_map[l] = s;
   endfunction

   function automatic int unsigned rise(int unsigned hole, logic [HeightBits-1:0] h,
                                        logic [LabelBits-1:0] l);
      while (hole > 1 && h > sky_h[hole/2]) begin
         put_entry(hole, sky_h[hole/2], sky_l[hole/2]);
         hole = hole / 2;
      end
      put_entry(hole, h, l);
      return hole;
   endfunction

   function automatic void sink(int unsigned hole);
      logic [HeightBits-1:0] h;
      logic [LabelBits-1:0] l;
      int unsigned c;
      h = sky_h[hole];
      l = sky_l[hole];
      while (2*hole <= live_count) begin
         c = 2*hole;
         if (c != live_count && sky_h[c+1] > sky_h[c]) c++;
         if (sky_h[c] > h) begin
            put_entry(hole, sky_h[c], sky_l[c]);
            hole = c;
         end else break;
      end
      put_entry(hole, h, l);
   endfunction

   function automatic bit is_live(logic [LabelBits-1:0] l);
      int unsigned s;
      s = slot_map[l];
      return s >= 1 && s <= live_count && sky_l[s] == l;
   endfunction

   function automatic void predict_skyline(req_type_type w);
      int unsigned s;
      logic [HeightBits-1:0] h, top;
      logic [LabelBits-1:0] l;
      rsp_type r;
      if (w.req_type == ReqInsert) begin
         if (live_count < MaxBuildings && !is_live(w.building_label)) begin
            live_count++;
            void'(rise(live_count, w.building_height, w.building_label));
         end
      end else if (is_live(w.building_label)) begin
         s = slot_map[w.building_label];
         h = sky_h[live_count];
         l = sky_l[live_count];
         live_count--;
         if (s <= live_count && rise(s, h, l) == s) sink(s);
      end
      if (!w.group_end) return;
      top = (live_count > 0) ? sky_h[1] : '0;
      if (top == last_height) return;
      last_height = top;
      r.change_x = w.x_coord;
      r.new_height = top;
      skyline_q.push_back(r);
      push_cnt++;
   endfunction

   // Sender: offers a word and waits until it is taken.
   task automatic send_word(req_type_type w);
      req_data <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_skyline(w);
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic req_type_type mk(int t, int x, int l, int h, int g);
      req_type_type w;
      w.req_type = t[0];
      w.x_coord = CoordBits'(x);
      w.building_label = LabelBits'(l);
      w.building_height = HeightBits'(h);
      w.group_end = g[0];
      return w;
   endfunction

   // Directed rows; chk marks rows whose result is typed in by hand.
   typedef struct {
      req_type_type w;
      bit chk;
      bit has_rsp;
      rsp_type r;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic void add_row(req_type_type w, int chk, int has, int x, int h);
      dir_row_type d;
      d.w = w;
      d.chk = (chk != 0);
      d.has_rsp = (has != 0);
      d.r.change_x = CoordBits'(x);
      d.r.new_height = HeightBits'(h);
      dir_rows.push_back(d);
   endfunction

   // Stimulus.
   initial begin
      int x, burst, k, q0;
      logic [LabelBits-1:0] lab;
      live_count = 0;
      last_height = '0;
      foreach (slot_map[i]) slot_map[i] = 0;
      foreach (sky_h[i]) begin
         sky_h[i] = '0;
         sky_l[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Removal of a missing label on an empty heap: nothing to report.
      add_row(mk(ReqRemove, 0, 0, 0, 1), 1, 0, 0, 0);
      add_row(mk(ReqInsert, 0, 0, 16'hffff, 1), 1, 1, 0, 16'hffff);
      add_row(mk(ReqInsert, 1, 255, 16'hffff, 1), 1, 0, 0, 0);
      add_row(mk(ReqInsert, 1, 255, 5, 0), 0, 0, 0, 0);
      add_row(mk(ReqInsert, 2, 255, 9, 1), 1, 0, 0, 0);  // label already live
      // The other building of the same height keeps the skyline where it is.
      add_row(mk(ReqRemove, 3, 0, 0, 1), 1, 0, 0, 0);
      add_row(mk(ReqRemove, 16'hffff, 255, 0, 1), 1, 1, 16'hffff, 0);
      add_row(mk(ReqInsert, 20, 1, 7, 0), 0, 0, 0, 0);
      add_row(mk(ReqInsert, 20, 2, 7, 0), 0, 0, 0, 0);
      add_row(mk(ReqInsert, 20, 3, 7, 1), 0, 0, 0, 0);
      add_row(mk(ReqRemove, 21, 2, 0, 1), 0, 0, 0, 0);
      add_row(mk(ReqInsert, 22, 4, 0, 1), 0, 0, 0, 0);
      add_row(mk(ReqRemove, 23, 1, 0, 0), 0, 0, 0, 0);
      add_row(mk(ReqRemove, 23, 3, 0, 1), 0, 0, 0, 0);
      add_row(mk(ReqRemove, 24, 4, 0, 1), 0, 0, 0, 0);
      add_row(mk(ReqRemove, 24, 9, 0, 1), 0, 0, 0, 0);
      foreach (dir_rows[i]) begin
         q0 = push_cnt;
         send_word(dir_rows[i].w);
         if (dir_rows[i].chk) begin
            if ((push_cnt != q0) != dir_rows[i].has_rsp) begin
               $error("row %0d: result presence expected %0b", i, dir_rows[i].has_rsp);
               errors++;
            end else if (dir_rows[i].has_rsp) begin
               if (skyline_q[$].change_x != dir_rows[i].r.change_x) begin
                  $error("row %0d: change_x expected %0d actual %0d", i,
                         dir_rows[i].r.change_x, skyline_q[$].change_x);
                  errors++;
               end
               if (skyline_q[$].new_height != dir_rows[i].r.new_height) begin
                  $error("row %0d: new_height expected %0d actual %0d", i,
                         dir_rows[i].r.new_height, skyline_q[$].new_height);
                  errors++;
               end
            end
         end
         idle_gap();
      end

      // Fill the heap past capacity with the receiver held off, then drain it.
      hold_off = 1;
      x = 100;
      for (int i = 0; i < 270; i++) begin
         send_word(mk(ReqInsert, x, i % 256, $urandom_range(0, 65535), 1));
         x++;
      end
      hold_off = 0;
      for (int i = 0; i < 256; i++) begin
         send_word(mk(ReqRemove, x, $urandom_range(0, 255), 0, $urandom_range(0, 1)));
         x++;
      end
      for (int i = 0; i < 256; i++) begin
         send_word(mk(ReqRemove, x, i, 0, 1));
         x++;
      end

      // Random sweep: mostly inserts of random labels and removals of live ones.
      k = 0;
      while (k < 1200) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            req_type_type w;
            x = x + ($urandom_range(0, 2) != 0);
            lab = LabelBits'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) begin
               w = mk($urandom_range(0, 1), $urandom_range(0, 65535), lab,
                      $urandom_range(0, 65535), $urandom_range(0, 1));
            end else if ($urandom_range(0, 1) == 0 || live_count < 2) begin
               w = mk(ReqInsert, x, lab,
                      $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 15), $urandom_range(0, 1));
            end else begin
               if (live_count > 0) lab = sky_l[$urandom_range(1, live_count)];
               w = mk(ReqRemove, x, lab, $urandom_range(0, 65535), $urandom_range(0, 1));
            end
            send_word(w);
            k++;
         end
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // Receiver: own stall pattern; long hold-off while the heap is filled.
   initial begin
      int hold_cnt;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (hold_off && hold_cnt < 3000) begin
            hold_cnt++;
            rsp_ready <= 1'b0;
         end else if ((($time / 1000) % 7) < 2) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (skyline_q.size() == 0) begin
            $error("unexpected word x=%0d height=%0d", rsp_data.change_x,
                   rsp_data.new_height);
            errors++;
         end else begin
            rsp_type e;
            e = skyline_q.pop_front();
            if (e.change_x != rsp_data.change_x) begin
               $error("change_x expected %0d actual %0d", e.change_x, rsp_data.change_x);
               errors++;
            end
            if (e.new_height != rsp_data.new_height) begin
               $error("new_height expected %0d actual %0d", e.new_height,
                      rsp_data.new_height);
               errors++;
            end
         end
      end
   end

   // End of run.
   initial begin
      wait (stim_done);
      while (skyline_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && skyline_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
